FILE: design/sbe_pkg.sv
// Shared types and codes for the stack bytecode executor.
// Used by every module of the block but sbe_ram; depends on nothing.
`timescale 1ns / 1ps

package sbe_pkg;

  // Request kinds
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_EXEC  = 2'd2;

  // Opcodes
  localparam logic [3:0] OP_EXIT  = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_PUSH  = 4'd2;
  localparam logic [3:0] OP_PRINT = 4'd3;
  localparam logic [3:0] OP_LT    = 4'd4;
  localparam logic [3:0] OP_LDA   = 4'd5;
  localparam logic [3:0] OP_STA   = 4'd6;
  localparam logic [3:0] OP_JZ    = 4'd7;
  localparam logic [3:0] OP_JMP   = 4'd8;
  localparam logic [3:0] OP_LDR   = 4'd9;
  localparam logic [3:0] OP_STR   = 4'd10;
  localparam logic [3:0] OP_CALL  = 4'd11;
  localparam logic [3:0] OP_RET   = 4'd12;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
  localparam logic [2:0] ERR_INDEX     = 3'd3;
  localparam logic [2:0] ERR_RETURN    = 3'd4;
  localparam logic [2:0] ERR_OPCODE    = 3'd5;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_LT
  } alu_op_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         opcode;
    logic signed [15:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic               halted;
    logic               print_valid;
    logic signed [15:0] print_value;
    logic signed [15:0] stack_bottom;
    logic [2:0]         error_code;
  } out_item_t;

endpackage

FILE: design/sbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sbe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sbe_alu.sv
// Shared 16-bit arithmetic/compare unit of the executor.
// Depends on sbe_pkg for the operation type.
`timescale 1ns / 1ps

module sbe_alu import sbe_pkg::*; (
  input  alu_op_e            op_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  output logic [15:0]        y_o
);

  always_comb begin
    unique case (op_i)
      ALU_ADD: y_o = a_i + b_i;
      ALU_LT:  y_o = (a_i < b_i) ? 16'd1 : 16'd0;
      default: y_o = '0;
    endcase
  end

endmodule

FILE: design/sbe_pcoff.sv
// Relative PC target: (pc + signed offset) mod PROGRAM_SIZE, three register stages.
// Reciprocal multiply with one correction; depends on sbe_pkg.
`timescale 1ns / 1ps

module sbe_pcoff import sbe_pkg::*; #(
  parameter int PROGRAM_SIZE = 1024
) (
  input  logic                            clk_i,
  input  logic [$clog2(PROGRAM_SIZE)-1:0] pc_i,
  input  logic signed [15:0]              off_i,
  output logic [$clog2(PROGRAM_SIZE)-1:0] pc_o
);

  localparam int PCW = $clog2(PROGRAM_SIZE);
  localparam int MW  = 33 - PCW;
  localparam int QW  = MW - 16;
  localparam int SW  = PCW + 1;
  localparam longint unsigned RECIP = (64'd1 << 32) / PROGRAM_SIZE;
  localparam int BIAS = (PROGRAM_SIZE - (32768 % PROGRAM_SIZE)) % PROGRAM_SIZE;
  localparam logic [MW-1:0] RECIP_W = MW'(RECIP);
  localparam logic [SW-1:0] PS_W    = SW'(PROGRAM_SIZE);
  localparam logic [SW-1:0] BIAS_W  = SW'(BIAS);

  // offset biased to unsigned: u = off + 32768
  logic [15:0]      u;
  logic [15:0]      u1_q, u2_q;
  logic [16+MW-1:0] prod1_q;
  logic [QW-1:0]    quot;
  logic [17:0]      prod2_q;
  logic [17:0]      rem, rem_fix;
  logic [PCW-1:0]   rem_q;
  logic [SW-1:0]    s, s_fix, t, t_fix;

  assign u    = {~off_i[15], off_i[14:0]};
  assign quot = prod1_q[16+MW-1:32];

  // quotient estimate may be one low
  assign rem     = {2'b00, u2_q} - prod2_q;
  assign rem_fix = (rem >= 18'(PS_W)) ? rem - 18'(PS_W) : rem;

  always_ff @(posedge clk_i) begin
    u1_q    <= u;
    prod1_q <= u * RECIP_W;
    u2_q    <= u1_q;
    prod2_q <= quot * PS_W;
    rem_q   <= rem_fix[PCW-1:0];
  end

  assign s     = {1'b0, rem_q} + BIAS_W;
  assign s_fix = (s >= PS_W) ? s - PS_W : s;
  assign t     = {1'b0, pc_i} + s_fix;
  assign t_fix = (t >= PS_W) ? t - PS_W : t;
  assign pc_o  = t_fix[PCW-1:0];

endmodule

FILE: design/stack_bybytecode_placeholder_never_used.sv
// Unused.
`timescale 1ns / 1ps

FILE: design/stack_bytecode_executor.sv
// Stack bytecode executor top level: sequencer, stack and return RAMs, result skid.
// Depends on sbe_pkg, sbe_ram, sbe_alu, sbe_pcoff.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//
// Push argument, start, exit, push immediate and any error finish in decode;
// print, loads, stores and return go on to execute; add and less-than pass a
// read state first; jump-if-zero, jump and call pass read and wait states, as set
// by the single read port of the data stack RAM and the three PC offset stages.
// Reset clears pointers, base, PC and the loading flag and sets the halted flag.
// RAM contents are not cleared. A stalled output holds one result in a skid
// register; a further transaction waits until that result moves on.
`timescale 1ns / 1ps

module stack_bytecode_executor import sbe_pkg::*; #(
  parameter int STACK_DEPTH  = 256,
  parameter int RETURN_DEPTH = 64,
  parameter int PROGRAM_SIZE = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int DAW = $clog2(STACK_DEPTH);
  localparam int RPW = $clog2(RETURN_DEPTH + 1);
  localparam int RAW = $clog2(RETURN_DEPTH);
  localparam int PCW = $clog2(PROGRAM_SIZE);
  localparam int RW  = PCW + 1;

  localparam logic [SPW-1:0] SP_MAX  = SPW'(STACK_DEPTH);
  localparam logic [RPW-1:0] RP_MAX  = RPW'(RETURN_DEPTH);
  localparam logic [PCW-1:0] PC_LAST = PCW'(PROGRAM_SIZE - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WT   = 3'd3;
  localparam logic [2:0] S_EXE  = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [RPW-1:0] rp_q, rp_d;
  logic [15:0]    fb_q, fb_d;
  logic [PCW-1:0] pc_q, pc_d;
  logic           stop_q, stop_d;
  logic           load_q, load_d;
  logic [15:0]    bottom_q, bottom_d;
  logic [15:0]    a_q, a_d;

  logic [1:0]         req_q;
  logic [3:0]         op_q;
  logic signed [15:0] opd_q;

  logic      res_valid_q, out_valid_q;
  out_item_t res_q, res_new, out_q;

  logic in_acc, move;

  // datapath
  logic [SPW-1:0] sp_m1, sp_m2, sp_p1, sp_push_base, sp_start_base, sp_start_p1;
  logic [RPW-1:0] rp_m1, rp_p1;
  logic [PCW-1:0] pc1, pc_jump;
  logic           sp_full, sp_empty, rp_full, rp_empty;
  logic [17:0]    idx;
  logic           idx_ok;
  logic [15:0]    alu_y;
  alu_op_e        alu_op;
  logic [PCW+9:0] pc_ext;

  // RAM ports
  logic           dwe, rwe;
  logic [DAW-1:0] dwaddr, draddr;
  logic [15:0]    dwdata, drdata;
  logic [RAW-1:0] rwaddr, rraddr;
  logic [RW-1:0]  rwdata, rrdata;

  logic           fin;
  logic [2:0]     err;
  logic           pv;
  logic [15:0]    pval;

  assign move       = res_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE) || (res_valid_q && !move);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign sp_m1    = sp_q - SPW'(1);
  assign sp_m2    = sp_q - SPW'(2);
  assign sp_p1    = sp_q + SPW'(1);
  assign rp_m1    = rp_q - RPW'(1);
  assign rp_p1    = rp_q + RPW'(1);
  assign sp_full  = (sp_q >= SP_MAX);
  assign sp_empty = (sp_q == '0);
  assign rp_full  = (rp_q >= RP_MAX);
  assign rp_empty = (rp_q == '0);
  assign pc1      = (pc_q == PC_LAST) ? '0 : pc_q + PCW'(1);

  // a push argument on a halted machine starts a fresh stack
  assign sp_push_base  = (stop_q && !load_q) ? '0 : sp_q;
  assign sp_start_base = load_q ? sp_q : '0;
  assign sp_start_p1   = sp_start_base + SPW'(1);

  assign idx    = {{2{opd_q[15]}}, opd_q}
                + (((op_q == OP_LDR) || (op_q == OP_STR)) ? {2'b00, fb_q} : 18'd0);
  assign idx_ok = !idx[17] && (idx[16:0] < 17'(sp_q));

  assign alu_op = (op_q == OP_LT) ? ALU_LT : ALU_ADD;

  sbe_alu u_alu (
    .op_i (alu_op),
    .a_i  (a_q),
    .b_i  (drdata),
    .y_o  (alu_y)
  );

  sbe_pcoff #(
    .PROGRAM_SIZE (PROGRAM_SIZE)
  ) u_pcoff (
    .clk_i (clk_i),
    .pc_i  (pc_q),
    .off_i (opd_q),
    .pc_o  (pc_jump)
  );

  sbe_ram #(
    .WIDTH (16),
    .DEPTH (STACK_DEPTH)
  ) u_dstack (
    .clk_i   (clk_i),
    .we_i    (dwe),
    .waddr_i (dwaddr),
    .wdata_i (dwdata),
    .raddr_i (draddr),
    .rdata_o (drdata)
  );

  sbe_ram #(
    .WIDTH (RW),
    .DEPTH (RETURN_DEPTH)
  ) u_rstack (
    .clk_i   (clk_i),
    .we_i    (rwe),
    .waddr_i (rwaddr),
    .wdata_i (rwdata),
    .raddr_i (rraddr),
    .rdata_o (rrdata)
  );

  always_comb begin
    state_d = state_q;
    sp_d    = sp_q;
    rp_d    = rp_q;
    fb_d    = fb_q;
    pc_d    = pc_q;
    stop_d  = stop_q;
    load_d  = load_q;
    a_d     = a_q;
    dwe     = 1'b0;
    dwaddr  = sp_q[DAW-1:0];
    dwdata  = opd_q;
    draddr  = sp_m1[DAW-1:0];
    rwe     = 1'b0;
    rwaddr  = rp_q[RAW-1:0];
    rwdata  = {1'b0, pc1};
    rraddr  = rp_m1[RAW-1:0];
    fin     = 1'b0;
    err     = ERR_NONE;
    pv      = 1'b0;
    pval    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        state_d = S_IDLE;
        fin     = 1'b1;
        if (req_q == REQ_PUSH) begin
          if (stop_q && !load_q) begin
            load_d = 1'b1;
          end
          sp_d = sp_push_base;
          if (sp_push_base >= SP_MAX) begin
            err = ERR_OVERFLOW;
          end else begin
            dwe    = 1'b1;
            dwaddr = sp_push_base[DAW-1:0];
            sp_d   = sp_push_base + SPW'(1);
          end
        end else if (req_q == REQ_START) begin
          load_d = 1'b0;
          sp_d   = sp_start_base;
          if (sp_start_base >= SP_MAX) begin
            err    = ERR_OVERFLOW;
            stop_d = 1'b1;
          end else begin
            dwe    = 1'b1;
            dwaddr = sp_start_base[DAW-1:0];
            dwdata = '0;
            sp_d   = sp_start_p1;
            rwe    = 1'b1;
            rwaddr = '0;
            rwdata = {1'b1, {PCW{1'b0}}};   // null return marker
            rp_d   = RPW'(1);
            fb_d   = 16'(sp_start_p1);
            pc_d   = '0;
            stop_d = 1'b0;
          end
        end else if ((req_q == REQ_EXEC) && !stop_q) begin
          unique case (op_q)
            OP_EXIT: stop_d = 1'b1;
            OP_ADD, OP_LT: begin
              if (sp_q < SPW'(2)) begin
                err = ERR_UNDERFLOW;
              end else begin
                draddr  = sp_m2[DAW-1:0];
                fin     = 1'b0;
                state_d = S_RD;
              end
            end
            OP_PUSH: begin
              if (sp_full) begin
                err = ERR_OVERFLOW;
              end else begin
                dwe  = 1'b1;
                sp_d = sp_p1;
                pc_d = pc1;
              end
            end
            OP_PRINT: begin
              if (sp_empty) begin
                err = ERR_UNDERFLOW;
              end else begin
                fin     = 1'b0;
                state_d = S_EXE;
              end
            end
            OP_LDA, OP_LDR: begin
              if (!idx_ok) begin
                err = ERR_INDEX;
              end else if (sp_full) begin
                err = ERR_OVERFLOW;
              end else begin
                draddr  = idx[DAW-1:0];
                fin     = 1'b0;
                state_d = S_EXE;
              end
            end
            OP_STA, OP_STR: begin
              if (sp_empty) begin
                err = ERR_UNDERFLOW;
              end else if (!idx_ok) begin
                err = ERR_INDEX;
              end else begin
                fin     = 1'b0;
                state_d = S_EXE;
              end
            end
            OP_JZ: begin
              if (sp_empty) begin
                err = ERR_UNDERFLOW;
              end else begin
                fin     = 1'b0;
                state_d = S_RD;
              end
            end
            OP_JMP: begin
              fin     = 1'b0;
              state_d = S_RD;
            end
            OP_CALL: begin
              if (sp_full) begin
                err = ERR_OVERFLOW;
              end else if (rp_full) begin
                err = ERR_RETURN;
              end else begin
                // save base and return address now, target PC at the end
                dwe     = 1'b1;
                dwdata  = fb_q;
                rwe     = 1'b1;
                sp_d    = sp_p1;
                rp_d    = rp_p1;
                fb_d    = 16'(sp_p1);
                fin     = 1'b0;
                state_d = S_RD;
              end
            end
            OP_RET: begin
              if (rp_empty) begin
                err = ERR_RETURN;
              end else if (sp_empty) begin
                err = ERR_UNDERFLOW;
              end else begin
                fin     = 1'b0;
                state_d = S_EXE;
              end
            end
            default: err = ERR_OPCODE;
          endcase
          if (err != ERR_NONE) begin
            stop_d = 1'b1;
          end
        end
      end

      S_RD: begin
        a_d = drdata;
        if ((op_q == OP_ADD) || (op_q == OP_LT)) begin
          state_d = S_EXE;
        end else begin
          state_d = S_WT;
        end
      end

      S_WT: state_d = S_EXE;

      S_EXE: begin
        state_d = S_IDLE;
        fin     = 1'b1;
        unique case (op_q)
          OP_ADD, OP_LT: begin
            dwe    = 1'b1;
            dwaddr = sp_m2[DAW-1:0];
            dwdata = alu_y;
            sp_d   = sp_m1;
            pc_d   = pc1;
          end
          OP_PRINT: begin
            pv   = 1'b1;
            pval = drdata;
            sp_d = sp_m1;
            pc_d = pc1;
          end
          OP_LDA, OP_LDR: begin
            dwe    = 1'b1;
            dwdata = drdata;
            sp_d   = sp_p1;
            pc_d   = pc1;
          end
          OP_STA, OP_STR: begin
            dwe    = 1'b1;
            dwaddr = idx[DAW-1:0];
            dwdata = drdata;
            sp_d   = sp_m1;
            pc_d   = pc1;
          end
          OP_JZ: begin
            sp_d = sp_m1;
            pc_d = (a_q == '0) ? pc_jump : pc1;
          end
          OP_JMP, OP_CALL: pc_d = pc_jump;
          OP_RET: begin
            rp_d = rp_m1;
            sp_d = sp_m1;
            fb_d = drdata;
            if (rrdata[PCW]) begin
              stop_d = 1'b1;
            end else begin
              pc_d = rrdata[PCW-1:0];
            end
          end
          default: ;
        endcase
      end

      default: state_d = S_IDLE;
    endcase
  end

  // entry zero is mirrored so the bottom slot needs no extra read
  assign bottom_d = (dwe && (dwaddr == '0)) ? dwdata : bottom_q;
  assign pc_ext   = {10'd0, pc_d};

  always_comb begin
    res_new.next_pc      = pc_ext[9:0];
    res_new.halted       = stop_d;
    res_new.print_valid  = pv;
    res_new.print_value  = pval;
    res_new.stack_bottom = (sp_d != '0) ? bottom_d : 16'd0;
    res_new.error_code   = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      rp_q        <= '0;
      fb_q        <= '0;
      pc_q        <= '0;
      stop_q      <= 1'b1;
      load_q      <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      rp_q    <= rp_d;
      fb_q    <= fb_d;
      pc_q    <= pc_d;
      stop_q  <= stop_d;
      load_q  <= load_d;
      if (fin) begin
        res_valid_q <= 1'b1;
      end else if (move) begin
        res_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bottom_q <= bottom_d;
    a_q      <= a_d;
    if (in_acc) begin
      req_q <= in_data_i.req_type;
      op_q  <= in_data_i.opcode;
      opd_q <= in_data_i.operand_value;
    end
    if (fin) begin
      res_q <= res_new;
    end
    if (move) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: dv/sbe_checker.sv
// Result checker for the stack bytecode executor: keeps its own copy of the machine
// state, predicts one result per accepted request and compares results field by field.
// Depends on sbe_pkg only; it watches the channels and drives nothing into the block.
`timescale 1ns / 1ps

module sbe_checker import sbe_pkg::*; #(
  parameter int STACK_DEPTH  = 256,
  parameter int RETURN_DEPTH = 64,
  parameter int PROGRAM_SIZE = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        results_o,
  output int        prints_o,
  output int        faults_o
);

  localparam int NULL_RET = 'h10000;  // return marker pushed by start

  logic [15:0] dstk [STACK_DEPTH];
  int          rstk [RETURN_DEPTH];
  int          sp = 0;
  int          fbase = 0;
  int          pc = 0;
  int          rp = 0;
  bit          stopped = 1'b1;
  bit          loading = 1'b0;

  out_item_t   results_due [$];
  int          n_fail = 0;
  int          n_pending = 0;
  int          n_results = 0;
  int          n_prints = 0;
  int          n_faults = 0;

  assign fail_count_o = n_fail;
  assign pending_o    = n_pending;
  assign results_o    = n_results;
  assign prints_o     = n_prints;
  assign faults_o     = n_faults;

  function automatic int pc_offset(int from, int off);
    int t;
    t = (from + off) % PROGRAM_SIZE;
    if (t < 0) t += PROGRAM_SIZE;
    return t;
  endfunction

  function automatic bit index_ok(int idx);
    return idx >= 0 && idx < sp;
  endfunction

  // One instruction on a running machine. On error nothing is changed here.
  function automatic logic [2:0] step_opcode(input logic [3:0] op, input int arg,
                                             output bit pv, output logic [15:0] pval);
    int                 pc1;
    int                 idx;
    int                 ret;
    logic signed [15:0] a;
    logic signed [15:0] b;
    pc1  = pc_offset(pc, 1);
    pv   = 1'b0;
    pval = '0;
    case (op)
      OP_EXIT: begin
        stopped = 1'b1;
        return ERR_NONE;
      end
      OP_ADD, OP_LT: begin
        if (sp < 2) return ERR_UNDERFLOW;
        a = dstk[sp-2];
        b = dstk[sp-1];
        sp--;
        dstk[sp-1] = (op == OP_ADD) ? 16'(a + b) : ((a < b) ? 16'd1 : 16'd0);
        pc = pc1;
      end
      OP_PUSH: begin
        if (sp >= STACK_DEPTH) return ERR_OVERFLOW;
        dstk[sp] = 16'(arg);
        sp++;
        pc = pc1;
      end
      OP_PRINT: begin
        if (sp == 0) return ERR_UNDERFLOW;
        sp--;
        pv   = 1'b1;
        pval = dstk[sp];
        pc   = pc1;
      end
      OP_LDA, OP_LDR: begin
        idx = (op == OP_LDA) ? arg : arg + fbase;
        if (!index_ok(idx)) return ERR_INDEX;
        if (sp >= STACK_DEPTH) return ERR_OVERFLOW;
        dstk[sp] = dstk[idx];
        sp++;
        pc = pc1;
      end
      OP_STA, OP_STR: begin
        if (sp == 0) return ERR_UNDERFLOW;
        idx = (op == OP_STA) ? arg : arg + fbase;
        if (!index_ok(idx)) return ERR_INDEX;
        dstk[idx] = dstk[sp-1];
        sp--;
        pc = pc1;
      end
      OP_JZ: begin
        if (sp == 0) return ERR_UNDERFLOW;
        sp--;
        pc = (dstk[sp] == 16'd0) ? pc_offset(pc, arg) : pc1;
      end
      OP_JMP: pc = pc_offset(pc, arg);
      OP_CALL: begin
        if (sp >= STACK_DEPTH) return ERR_OVERFLOW;
        if (rp >= RETURN_DEPTH) return ERR_RETURN;
        dstk[sp] = 16'(fbase);
        sp++;
        rstk[rp] = pc1;
        rp++;
        fbase = sp;
        pc    = pc_offset(pc, arg);
      end
      OP_RET: begin
        if (rp == 0) return ERR_RETURN;
        if (sp == 0) return ERR_UNDERFLOW;
        rp--;
        ret = rstk[rp];
        sp--;
        fbase = int'(dstk[sp]);  // saved base comes back unsigned
        if ((ret & NULL_RET) != 0) stopped = 1'b1;
        else pc = ret % PROGRAM_SIZE;
      end
      default: return ERR_OPCODE;
    endcase
    return ERR_NONE;
  endfunction

  function automatic out_item_t interpret_request(in_item_t req);
    out_item_t   res;
    logic [2:0]  err;
    bit          pv;
    logic [15:0] pval;
    err  = ERR_NONE;
    pv   = 1'b0;
    pval = '0;
    case (req.req_type)
      REQ_PUSH: begin
        // first argument after a halt starts a fresh stack
        if (stopped && !loading) begin
          sp      = 0;
          loading = 1'b1;
        end
        if (sp >= STACK_DEPTH) err = ERR_OVERFLOW;
        else begin
          dstk[sp] = req.operand_value;
          sp++;
        end
      end
      REQ_START: begin
        if (!loading) sp = 0;
        loading = 1'b0;
        if (sp >= STACK_DEPTH) begin
          err     = ERR_OVERFLOW;
          stopped = 1'b1;
        end else begin
          dstk[sp] = '0;
          sp++;
          rstk[0] = NULL_RET;
          rp      = 1;
          fbase   = sp;
          pc      = 0;
          stopped = 1'b0;
        end
      end
      REQ_EXEC: begin
        if (!stopped) begin
          err = step_opcode(req.opcode, int'(req.operand_value), pv, pval);
          if (err != ERR_NONE) stopped = 1'b1;
        end
      end
      default: ;
    endcase
    res.next_pc      = 10'(pc);
    res.halted       = stopped;
    res.print_valid  = pv;
    res.print_value  = pval;
    res.stack_bottom = (sp > 0) ? dstk[0] : '0;
    res.error_code   = err;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    n_fail++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result transaction with no request outstanding");
    end else begin
      want = results_due.pop_front();
      n_results++;
      if (want.print_valid) n_prints++;
      if (want.error_code != ERR_NONE) n_faults++;
      check_field("next_pc", 16'(got.next_pc), 16'(want.next_pc));
      check_field("halted", 16'(got.halted), 16'(want.halted));
      check_field("print_valid", 16'(got.print_valid), 16'(want.print_valid));
      check_field("print_value", got.print_value, want.print_value);
      check_field("stack_bottom", got.stack_bottom, want.stack_bottom);
      check_field("error_code", 16'(got.error_code), 16'(want.error_code));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp      = 0;
      fbase   = 0;
      pc      = 0;
      rp      = 0;
      stopped = 1'b1;
      loading = 1'b0;
      results_due.delete();
      n_pending <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) results_due = {results_due, interpret_request(in_data_i)};
      if (out_valid_i && !out_stall_i) compare_result(out_data_i);
      n_pending <= results_due.size();
    end
  end

endmodule

FILE: dv/tb.sv
// Testbench top for the stack bytecode executor: clock, reset, request stimulus,
// result-side stalls, watchdog and verdict. Depends on sbe_pkg, the block and sbe_checker.
`timescale 1ns / 1ps

module tb;
  import sbe_pkg::*;

  localparam int STACK_DEPTH  = 256;
  localparam int RETURN_DEPTH = 64;
  localparam int PROGRAM_SIZE = 1024;
  localparam int ITEM_TARGET  = 1550;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either channel
  localparam int DRAIN_CYCLES = 16;

  localparam logic [1:0] REQ_NONE = 2'd3;  // request kind the block ignores

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  int fail_count;
  int pending;
  int n_results;
  int n_prints;
  int n_faults;

  int idle_cycles = 0;
  bit calm = 1'b0;

  // rough view of the machine, used only to shape stimulus
  int est_sp = 0;
  int est_rp = 0;
  int est_base = 0;
  int base_trail [$];
  bit est_halted = 1'b1;

  int n_counted = 0;
  int n_programs = 0;

  stack_bytecode_executor #(
    .STACK_DEPTH (STACK_DEPTH),
    .RETURN_DEPTH(RETURN_DEPTH),
    .PROGRAM_SIZE(PROGRAM_SIZE)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  sbe_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .RETURN_DEPTH(RETURN_DEPTH),
    .PROGRAM_SIZE(PROGRAM_SIZE)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (n_results),
    .prints_o    (n_prints),
    .faults_o    (n_faults)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic signed [15:0] jump_offset();
    if ($urandom_range(7) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(64)) - 32);
  endfunction

  // result-side stalls: bursts of random length, none while calm
  initial begin
    int hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) hold--;
      else if (!calm && $urandom_range(99) < 30) hold = pick_gap();
      out_stall_i <= (hold > 0);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic [1:0] kind, logic [3:0] op, logic signed [15:0] val);
    in_item_t req;
    int       gap;
    req.req_type      = kind;
    req.opcode        = op;
    req.operand_value = val;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (kind != REQ_NONE && !(kind == REQ_EXEC && est_halted)) n_counted++;
  endtask

  task automatic directed_checks();
    est_halted = 1'b1;
    send_request(REQ_EXEC, OP_ADD, 16'h0000);     // nothing runs yet
    send_request(REQ_NONE, OP_PUSH, 16'hFFFF);
    est_halted = 1'b0;
    send_request(REQ_PUSH, OP_EXIT, 16'h7FFF);    // result slot
    send_request(REQ_PUSH, OP_EXIT, 16'h8000);
    send_request(REQ_START, OP_EXIT, 16'h0000);
    send_request(REQ_EXEC, OP_LDA, 16'h0000);
    send_request(REQ_EXEC, OP_PUSH, 16'h0001);
    send_request(REQ_EXEC, OP_ADD, 16'h0000);     // 0x7fff + 1 wraps
    send_request(REQ_EXEC, OP_LT, 16'h0000);
    send_request(REQ_EXEC, OP_JZ, 16'hFFFB);      // back past address zero
    send_request(REQ_EXEC, OP_CALL, 16'd100);
    send_request(REQ_EXEC, OP_PUSH, 16'd5);
    send_request(REQ_EXEC, OP_LDR, 16'hFFFF);     // saved base, below the frame
    send_request(REQ_EXEC, OP_STR, 16'h0000);
    send_request(REQ_EXEC, OP_PRINT, 16'h0000);
    send_request(REQ_EXEC, OP_RET, 16'h0000);
    send_request(REQ_EXEC, OP_STA, 16'h0000);
    send_request(REQ_EXEC, OP_JMP, 16'hF830);     // large negative jump
    send_request(REQ_EXEC, OP_RET + 4'd1, 16'h7FFF);
    send_request(REQ_START, OP_RET, 16'h0000);
    send_request(REQ_PUSH, OP_EXIT, 16'd42);      // argument while running
    send_request(REQ_START, OP_EXIT, 16'h0000);   // restart while running
    send_request(REQ_EXEC, OP_EXIT, 16'h0000);
    send_request(REQ_START, OP_EXIT, 16'h0000);
    send_request(REQ_EXEC, OP_RET, 16'h0000);     // pops the null marker
    send_request(REQ_START, OP_EXIT, 16'h0000);
    send_request(REQ_EXEC, OP_LDA, 16'h7FFF);     // index far out of range
    est_halted = 1'b1;
  endtask

  task automatic issue_instruction();
    int                 r;
    logic [3:0]         op;
    logic signed [15:0] val;
    r   = $urandom_range(99);
    val = 16'($urandom);
    op  = OP_PUSH;
    if (r < 5) op = 4'($urandom_range(15));
    else if (est_sp < 2 && r < 50) op = OP_PUSH;
    else if (r < 20) op = OP_PUSH;
    else if (r < 30 && est_sp >= 2) op = OP_ADD;
    else if (r < 36 && est_sp >= 2) op = OP_LT;
    else if (r < 43 && est_sp >= 1) op = OP_PRINT;
    else if (r < 50 && est_sp >= 1) begin
      op  = OP_LDA;
      val = 16'($urandom_range(est_sp - 1));
    end else if (r < 56 && est_sp >= 1) begin
      op  = OP_STA;
      val = 16'($urandom_range(est_sp - 1));
    end else if (r < 62 && est_sp >= 1) begin
      op  = OP_LDR;
      val = 16'(int'($urandom_range(est_sp - 1)) - est_base);
    end else if (r < 68 && est_sp >= 1) begin
      op  = OP_STR;
      val = 16'(int'($urandom_range(est_sp - 1)) - est_base);
    end else if (r < 75 && est_sp >= 1) begin
      op  = OP_JZ;
      val = jump_offset();
    end else if (r < 80) begin
      op  = OP_JMP;
      val = jump_offset();
    end else if (r < 89 && est_rp < RETURN_DEPTH - 2) begin
      op  = OP_CALL;
      val = jump_offset();
    end else if (r < 98 && (est_rp > 1 || r == 97)) op = OP_RET;
    else if (r == 99) op = OP_EXIT;
    send_request(REQ_EXEC, op, val);
    case (op)
      OP_PUSH, OP_LDA, OP_LDR: est_sp++;
      OP_ADD, OP_LT, OP_PRINT, OP_STA, OP_STR, OP_JZ: if (est_sp > 0) est_sp--;
      OP_JMP: ;
      OP_CALL: begin
        est_sp++;
        est_rp++;
        base_trail = {base_trail, est_base};
        est_base = est_sp;
      end
      OP_RET: begin
        if (est_sp > 0) est_sp--;
        est_rp--;
        if (base_trail.size() > 0) begin
          est_base = base_trail[base_trail.size() - 1];
          base_trail.delete(base_trail.size() - 1);
        end
        if (est_rp <= 0) est_halted = 1'b1;
      end
      default: est_halted = 1'b1;  // exit or invalid opcode
    endcase
  endtask

  task automatic run_program();
    int nargs;
    int len;
    int r;
    nargs = ($urandom_range(2) == 0) ? $urandom_range(4, 1) : 0;
    // arguments after a halt sit on a fresh stack under the start frame
    est_sp = (est_halted && nargs > 0) ? nargs + 1 : 1;
    repeat (nargs) send_request(REQ_PUSH, 4'($urandom), 16'($urandom));
    send_request(REQ_START, 4'($urandom), 16'($urandom));
    est_rp   = 1;
    est_base = est_sp;
    base_trail.delete();
    est_halted = 1'b0;
    len = $urandom_range(40, 3);
    for (int i = 0; i < len && !est_halted; i++) begin
      r = $urandom_range(99);
      if (r < 2) send_request(REQ_NONE, 4'($urandom), 16'($urandom));
      else if (r < 4) begin
        send_request(REQ_PUSH, 4'($urandom), 16'($urandom));
        est_sp++;
      end else issue_instruction();
    end
  endtask

  // argument pushes past the stack depth, then a start on the full stack
  task automatic fill_with_arguments();
    send_request(REQ_EXEC, OP_EXIT, 16'h0000);
    est_halted = 1'b1;
    repeat (STACK_DEPTH + 1) send_request(REQ_PUSH, 4'($urandom), 16'($urandom));
    send_request(REQ_START, 4'($urandom), 16'($urandom));
  endtask

  task automatic fill_with_pushes();
    send_request(REQ_START, 4'($urandom), 16'($urandom));
    est_halted = 1'b0;
    repeat (STACK_DEPTH - 1) send_request(REQ_EXEC, OP_PUSH, 16'($urandom));
    case ($urandom_range(2))
      0: send_request(REQ_EXEC, OP_PUSH, 16'($urandom));
      1: send_request(REQ_EXEC, OP_LDA, 16'h0000);
      default: send_request(REQ_EXEC, OP_CALL, jump_offset());
    endcase
    est_halted = 1'b1;
  endtask

  // one call more than the return stack holds
  task automatic nest_calls();
    send_request(REQ_START, 4'($urandom), 16'($urandom));
    est_halted = 1'b0;
    repeat (RETURN_DEPTH) send_request(REQ_EXEC, OP_CALL, jump_offset());
    est_halted = 1'b1;
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    directed_checks();
    while (n_counted < ITEM_TARGET) begin
      calm = ($urandom_range(4) == 0);
      case (n_programs)
        8: fill_with_arguments();
        20: nest_calls();
        32: fill_with_pushes();
        default: run_program();
      endcase
      n_programs++;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Summary: %0d requests in %0d programs, %0d results checked", n_counted,
             n_programs, n_results);
    $display("Summary: %0d prints and %0d error results seen", n_prints, n_faults);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
